// ===== src/suffix_trie_build_and_match_unit_defines.svh =====
// Assertion macros shared by the checker files of the suffix trie unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SUFFIX_TRIE_BUILD_AND_MATCH_UNIT_DEFINES_SVH
`define SUFFIX_TRIE_BUILD_AND_MATCH_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define STBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stbm_pkg.sv =====
package stbm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int WIN_AW     = $clog2(WINDOW_MAX);
  localparam int WCNT_W     = WIN_AW + 1;

  localparam int NODE_MAX   = 4096;
  localparam int NODE_W     = $clog2(NODE_MAX);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LINK_AW    = NODE_W + 2;
  localparam int LINK_DEPTH = NODE_MAX * 4;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_BUILD = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_OVF   = 2'd1;
  localparam logic [1:0] STATUS_WFULL = 2'd2;

  // Raw base code flattened to 0..3 by its highest set bit.
  localparam logic [1:0] FLAT_TABLE [16] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
  };

endpackage

// ===== src/suffix_trie_build_and_match_unit.sv =====
// Suffix trie build and match unit.
// Requests arrive on the s_axis channel: tuser carries the mode (clear, load a
// window base, build the trie, query a pattern base), tdata carries the base code
// and tlast marks the final base of a query pattern. Every request produces
// exactly one result on the m_axis channel: tdata carries found and the status,
// and tlast is high when the request ended a pattern query.
// Clear, load and a query step that starts at the root or follows a dead walk
// answer in the cycle after acceptance. A live query step below the root waits
// in ST_QRY on the registered link memory read and then registers its answer.
// A build walks every suffix through one shared link lookup and compare step.
// Each walked base takes a window read, a link read and a check, and each new
// node takes four zeroing writes on the single write port of the link memory,
// then one link write, or a root table write when its parent is the root.
// The unit takes one request at a time; s_axis_tready is low while a build or a
// query lookup is in flight. A finished result sits in an output register, and a
// new request is taken as soon as that register is empty or being drained, so a
// stalled receiver stalls the input after one waiting result.
// Reset empties the window, cuts the trie to a bare root held in flip-flops and
// restarts any pattern walk; the link and window memories need no clearing pass.
module suffix_trie_build_and_match_unit
  import stbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] base_code, [7:4] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  input  logic       s_axis_tlast,   // last_base
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] found, [2:1] status, [7:3] zero
  output logic       m_axis_tlast    // query_done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QRY,
    ST_B_START,
    ST_B_WIN,
    ST_B_LINK,
    ST_B_CHK,
    ST_B_ZERO,
    ST_B_SET
  } state_e;

  state_e              state_q;
  logic [WCNT_W-1:0]   win_cnt_q;
  logic [FREE_W-1:0]   free_q;
  logic [NODE_W-1:0]   qnode_q;
  logic                alive_q;
  logic                ovf_q;
  logic                q_last_q;
  logic [NODE_W-1:0]   root_q [4];
  logic [WCNT_W-1:0]   start_q;
  logic [WCNT_W-1:0]   pos_q;
  logic [NODE_W-1:0]   node_q;
  logic [1:0]          base_q;
  logic [NODE_W-1:0]   new_q;
  logic [1:0]          zcnt_q;
  logic                from_root_q;
  logic [NODE_W-1:0]   root_link_q;
  logic                out_valid_q;
  logic                out_found_q;
  logic                out_done_q;
  logic [1:0]          out_status_q;

  // Link memory (child pointers of non-root nodes) and window memory.
  logic [NODE_W-1:0]   link_mem [LINK_DEPTH];
  logic [NODE_W-1:0]   link_rd_q;
  logic [1:0]          win_mem [WINDOW_MAX];
  logic [1:0]          win_rd_q;

  logic                accept;
  mode_e               in_mode;
  logic [1:0]          in_base;
  logic [1:0]          root_idx;
  logic [NODE_W-1:0]   root_rd;
  logic [LINK_AW-1:0]  link_raddr;
  logic                link_we;
  logic [LINK_AW-1:0]  link_waddr;
  logic [NODE_W-1:0]   link_wdata;
  logic                win_we;
  logic [NODE_W-1:0]   link_next;
  logic [NODE_W-1:0]   q_link;
  logic                q_hit;
  logic                q_last;

  assign in_mode       = mode_e'(s_axis_tuser);
  assign in_base       = s_axis_tdata[1:0];
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The root table has a single read address, shared by queries and the build.
  assign root_idx = (state_q == ST_IDLE) ? in_base : win_rd_q;
  assign root_rd  = root_q[root_idx];

  assign link_raddr = (state_q == ST_IDLE) ? {qnode_q, in_base} : {node_q, win_rd_q};
  assign link_we    = (state_q == ST_B_ZERO) || ((state_q == ST_B_SET) && (node_q != '0));
  assign link_waddr = (state_q == ST_B_ZERO) ? {new_q, zcnt_q} : {node_q, base_q};
  assign link_wdata = (state_q == ST_B_ZERO) ? '0 : new_q;
  assign win_we     = accept && (in_mode == MODE_LOAD) && (win_cnt_q < WCNT_W'(WINDOW_MAX));

  // Shared lookup result for the build walk and for a query step.
  assign link_next = from_root_q ? root_link_q : link_rd_q;
  assign q_link    = (state_q == ST_QRY) ? link_rd_q : root_rd;
  assign q_hit     = alive_q && (q_link != '0);
  assign q_last    = (state_q == ST_QRY) ? q_last_q : s_axis_tlast;

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_cnt_q[WIN_AW-1:0]] <= FLAT_TABLE[s_axis_tdata[3:0]];
    end
    win_rd_q <= win_mem[pos_q[WIN_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_cnt_q    <= '0;
      free_q       <= FREE_W'(1);
      qnode_q      <= '0;
      alive_q      <= 1'b1;
      ovf_q        <= 1'b0;
      q_last_q     <= 1'b0;
      for (int i = 0; i < 4; i++) root_q[i] <= '0;
      start_q      <= '0;
      pos_q        <= '0;
      node_q       <= '0;
      base_q       <= '0;
      new_q        <= '0;
      zcnt_q       <= '0;
      from_root_q  <= 1'b0;
      root_link_q  <= '0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_done_q   <= 1'b0;
      out_status_q <= STATUS_OK;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              MODE_CLEAR: begin
                win_cnt_q <= '0;
                for (int i = 0; i < 4; i++) root_q[i] <= '0;
                free_q       <= FREE_W'(1);
                qnode_q      <= '0;
                alive_q      <= 1'b1;
                ovf_q        <= 1'b0;
                out_valid_q  <= 1'b1;
                out_found_q  <= 1'b0;
                out_done_q   <= 1'b0;
                out_status_q <= STATUS_OK;
              end
              MODE_LOAD: begin
                out_valid_q <= 1'b1;
                out_found_q <= 1'b0;
                out_done_q  <= 1'b0;
                if (win_we) begin
                  win_cnt_q    <= win_cnt_q + WCNT_W'(1);
                  out_status_q <= STATUS_OK;
                end else begin
                  out_status_q <= STATUS_WFULL;
                end
              end
              MODE_BUILD: begin
                for (int i = 0; i < 4; i++) root_q[i] <= '0;
                free_q  <= FREE_W'(1);
                qnode_q <= '0;
                alive_q <= 1'b1;
                ovf_q   <= 1'b0;
                start_q <= '0;
                state_q <= ST_B_START;
              end
              MODE_QUERY: begin
                if (alive_q && (qnode_q != '0)) begin
                  // Child lies in the link memory: wait for the read.
                  q_last_q <= s_axis_tlast;
                  state_q  <= ST_QRY;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ovf_q ? STATUS_OVF : STATUS_OK;
                  out_done_q   <= q_last;
                  out_found_q  <= q_last && q_hit;
                  if (q_last) begin
                    qnode_q <= '0;
                    alive_q <= 1'b1;
                  end else begin
                    alive_q <= q_hit;
                    if (q_hit) qnode_q <= q_link;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        ST_QRY: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ovf_q ? STATUS_OVF : STATUS_OK;
          out_done_q   <= q_last;
          out_found_q  <= q_last && q_hit;
          if (q_last) begin
            qnode_q <= '0;
            alive_q <= 1'b1;
          end else begin
            alive_q <= q_hit;
            if (q_hit) qnode_q <= q_link;
          end
          state_q <= ST_IDLE;
        end

        ST_B_START: begin
          if (start_q == win_cnt_q) begin
            out_valid_q  <= 1'b1;
            out_found_q  <= 1'b0;
            out_done_q   <= 1'b0;
            out_status_q <= STATUS_OK;
            state_q      <= ST_IDLE;
          end else begin
            pos_q   <= start_q;
            node_q  <= '0;
            state_q <= ST_B_WIN;
          end
        end

        ST_B_WIN: begin
          // The window read at pos_q is issued in this cycle.
          if (pos_q == win_cnt_q) begin
            start_q <= start_q + WCNT_W'(1);
            state_q <= ST_B_START;
          end else begin
            state_q <= ST_B_LINK;
          end
        end

        ST_B_LINK: begin
          // The link read at {node, base} is issued in this cycle.
          base_q      <= win_rd_q;
          root_link_q <= root_rd;
          from_root_q <= (node_q == '0);
          state_q     <= ST_B_CHK;
        end

        ST_B_CHK: begin
          if (link_next != '0) begin
            node_q  <= link_next;
            pos_q   <= pos_q + WCNT_W'(1);
            state_q <= ST_B_WIN;
          end else if (free_q == FREE_W'(NODE_MAX)) begin
            // Out of nodes: stop, keep what was built and flag it.
            ovf_q        <= 1'b1;
            out_valid_q  <= 1'b1;
            out_found_q  <= 1'b0;
            out_done_q   <= 1'b0;
            out_status_q <= STATUS_OVF;
            state_q      <= ST_IDLE;
          end else begin
            new_q   <= free_q[NODE_W-1:0];
            free_q  <= free_q + FREE_W'(1);
            zcnt_q  <= '0;
            state_q <= ST_B_ZERO;
          end
        end

        ST_B_ZERO: begin
          zcnt_q <= zcnt_q + 2'd1;
          if (zcnt_q == 2'd3) begin
            state_q <= ST_B_SET;
          end
        end

        ST_B_SET: begin
          if (node_q == '0) begin
            root_q[base_q] <= new_q;
          end
          node_q  <= new_q;
          pos_q   <= pos_q + WCNT_W'(1);
          state_q <= ST_B_WIN;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_status_q, out_found_q};
  assign m_axis_tlast  = out_done_q;

endmodule

// ===== src/stbm_checker.sv =====
`include "suffix_trie_build_and_match_unit_defines.svh"

module stbm_checker
  import stbm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic in_acc;
  logic quick_req;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign quick_req = (s_axis_tuser == MODE_CLEAR) || (s_axis_tuser == MODE_LOAD);

  // A waiting result holds still until it is taken.
  `STBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // Found is only ever reported on a finished query.
  `STBM_ASSERT_NOW(a_found_done, m_axis_tvalid && m_axis_tdata[0], m_axis_tlast,
    "found without query_done")

  // Status is always one of the defined codes.
  `STBM_ASSERT_NOW(a_status_code, m_axis_tvalid,
    (m_axis_tdata[2:1] == STATUS_OK) || (m_axis_tdata[2:1] == STATUS_OVF) ||
    (m_axis_tdata[2:1] == STATUS_WFULL), "undefined status code")

  // Clear and load requests answer in the next cycle and never end a query.
  `STBM_ASSERT_NEXT(a_quick_reply, in_acc && quick_req,
    m_axis_tvalid && !m_axis_tlast && !m_axis_tdata[0], "clear or load reply missing")

endmodule

bind suffix_trie_build_and_match_unit stbm_checker u_stbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/suffix_trie_build_and_match_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the suffix trie unit. A generator fills a backlog of
// requests (a short directed list, then clear/load/build/query scenarios with
// random content and some noise). A clocked driver sends them in bursts, and a
// clocked monitor predicts each accepted request and checks every answer in order.
module suffix_trie_build_and_match_unit_tb;
  import stbm_pkg::*;

  typedef struct {
    mode_e      mode;
    logic [3:0] code;
    logic       last;
    bit         drain;  // hold this request until every answer is in
  } trie_req_t;

  typedef struct packed {
    logic       found;
    logic       done;
    logic [1:0] status;
  } trie_ans_t;

  typedef logic [1:0] base_seq_t[$];

  localparam int RANDOM_REQS  = 1900;
  localparam int REPORT_LIMIT = 100;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [3:0] base_code, [7:4] zero
  logic [1:0] s_axis_tuser  = '0;  // [1:0] mode
  logic       s_axis_tlast  = 1'b0;  // last_base
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;   // [0] found, [2:1] status, [7:3] zero
  logic       m_axis_tlast;   // query_done

  suffix_trie_build_and_match_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run-wide bookkeeping.
  trie_req_t req_backlog[$];
  trie_ans_t answers_due[$];
  int        total_reqs    = 0;
  int        accepted_reqs = 0;
  int        err_cnt       = 0;
  bit        req_fire      = 1'b0;

  int n_builds = 0, widest_build = 0, n_queries = 0, n_found = 0, n_refused = 0;

  // Shadow state of the trie unit, kept by the predictor.
  logic [NODE_W-1:0] kid_link [LINK_DEPTH];
  logic [1:0]        win_base [WINDOW_MAX];
  int                win_len;
  int                free_next;
  int                walk_node;
  bit                walk_alive;
  bit                store_full;

  // Window as the generator sees it, and the window at the latest build.
  base_seq_t gen_win;
  base_seq_t gen_built;

  // A raw code flattens to the index of its highest set bit; 0 and 1 both give 0.
  function automatic logic [1:0] base_of_code(input logic [3:0] c);
    if (c[3]) return 2'd3;
    if (c[2]) return 2'd2;
    if (c[1]) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [3:0] raw_code(input logic [1:0] b);
    case (b)
      2'd0: return 4'($urandom_range(0, 1));
      2'd1: return 4'($urandom_range(2, 3));
      2'd2: return 4'($urandom_range(4, 7));
      default: return 4'($urandom_range(8, 15));
    endcase
  endfunction

  function automatic void trie_bare();
    for (int b = 0; b < 4; b++) kid_link[b] = '0;
    free_next = 1;
  endfunction

  task automatic walk_home();
    walk_node  = 0;
    walk_alive = 1'b1;
  endtask

  // Inserts every suffix of the window; returns 0 when the node store runs out.
  function automatic bit grow_suffix_trie();
    int node, slot, nxt;
    trie_bare();
    for (int st = 0; st < win_len; st++) begin
      node = 0;
      for (int pos = st; pos < win_len; pos++) begin
        slot = node * 4 + win_base[pos];
        nxt  = kid_link[slot];
        if (nxt == 0) begin
          if (free_next >= NODE_MAX) return 1'b0;
          nxt = free_next;
          free_next++;
          for (int b = 0; b < 4; b++) kid_link[nxt * 4 + b] = '0;
          kid_link[slot] = NODE_W'(nxt);
        end
        node = nxt;
      end
    end
    return 1'b1;
  endfunction

  task automatic trie_model_step(input trie_req_t r, output trie_ans_t a);
    int nxt;
    a = '0;
    case (r.mode)
      MODE_CLEAR: begin
        win_len = 0;
        trie_bare();
        walk_home();
        store_full = 1'b0;
      end
      MODE_LOAD: begin
        if (win_len < WINDOW_MAX) begin
          win_base[win_len] = base_of_code(r.code);
          win_len++;
        end else begin
          a.status = STATUS_WFULL;
        end
      end
      MODE_BUILD: begin
        walk_home();
        store_full = !grow_suffix_trie();
        if (store_full) a.status = STATUS_OVF;
      end
      default: begin
        // Only the low two bits of the code select the child during a walk.
        if (walk_alive) begin
          nxt = kid_link[walk_node * 4 + r.code[1:0]];
          if (nxt == 0 || nxt >= NODE_MAX) walk_alive = 1'b0;
          else walk_node = nxt;
        end
        if (r.last) begin
          a.found = walk_alive;
          a.done  = 1'b1;
          walk_home();
        end
        if (store_full) a.status = STATUS_OVF;
      end
    endcase
  endtask

  // Queues one request and keeps the generator's view of the window current.
  task automatic push_req(input mode_e m, input logic [3:0] c, input logic l,
                          input bit d);
    trie_req_t r;
    r.mode  = m;
    r.code  = c;
    r.last  = l;
    r.drain = d;
    req_backlog.push_back(r);
    case (m)
      MODE_CLEAR: begin
        gen_win.delete();
        gen_built.delete();
      end
      MODE_LOAD:  if (gen_win.size() < WINDOW_MAX) gen_win.push_back(base_of_code(c));
      MODE_BUILD: gen_built = gen_win;
      default: ;
    endcase
  endtask

  // Sends a pattern as query requests; junk goes into the unused code bits.
  task automatic push_pattern(input base_seq_t pat, input bit finish);
    logic [1:0] junk;
    for (int i = 0; i < pat.size(); i++) begin
      junk = 2'($urandom_range(0, 3));
      push_req(MODE_QUERY, {junk, pat[i]}, finish && (i == pat.size() - 1), 1'b0);
    end
  endtask

  task automatic add_noise(input int n);
    mode_e m;
    for (int i = 0; i < n; i++) begin
      m = mode_e'($urandom_range(0, 3));
      // Keep stray builds cheap.
      if (m == MODE_BUILD && gen_win.size() > 24) m = MODE_QUERY;
      push_req(m, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // One well-formed pass: clear (usually), load a window, build, then queries, sometimes followed by noise.
  task automatic add_scenario(input int wlen, input bit drain);
    int        nq, kind, st, len;
    bit        first;
    base_seq_t pat;
    first = drain;
    if ($urandom_range(0, 5) != 0 || gen_win.size() + wlen > 24) begin
      push_req(MODE_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), first);
      first = 1'b0;
    end
    for (int i = 0; i < wlen; i++) begin
      push_req(MODE_LOAD, raw_code(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
               first);
      first = 1'b0;
    end
    push_req(MODE_BUILD, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), first);
    nq = $urandom_range(3, 10);
    for (int q = 0; q < nq; q++) begin
      kind = $urandom_range(0, 9);
      pat.delete();
      if ((kind <= 5 || kind == 9) && gen_built.size() != 0) begin
        st  = $urandom_range(0, gen_built.size() - 1);
        len = $urandom_range(1, (gen_built.size() - st < 8) ? gen_built.size() - st : 8);
        for (int i = 0; i < len; i++) pat.push_back(gen_built[st + i]);
        // Near miss: the final base is replaced at random.
        if (kind == 9) pat[len - 1] = 2'($urandom_range(0, 3));
        push_pattern(pat, 1'b1);
      end else if (kind == 8) begin
        // A walk left open; whatever follows has to cope with it.
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) pat.push_back(2'($urandom_range(0, 3)));
        push_pattern(pat, 1'b0);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) pat.push_back(2'($urandom_range(0, 3)));
        push_pattern(pat, 1'b1);
      end
    end
    if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 5));
  endtask

  // Directed opening: empty trie, every raw code extreme, found, dead walk,
  // a walk cut short by a build, and a query after clear.
  task automatic load_directed();
    push_req(MODE_QUERY, 4'hF, 1'b1, 1'b0);
    push_req(MODE_BUILD, 4'h0, 1'b0, 1'b0);
    push_req(MODE_QUERY, 4'h0, 1'b1, 1'b0);
    push_req(MODE_LOAD, 4'h0, 1'b0, 1'b0);
    push_req(MODE_LOAD, 4'h1, 1'b1, 1'b0);
    push_req(MODE_LOAD, 4'h2, 1'b0, 1'b0);
    push_req(MODE_LOAD, 4'h4, 1'b0, 1'b0);
    push_req(MODE_LOAD, 4'h8, 1'b0, 1'b0);
    push_req(MODE_LOAD, 4'hF, 1'b0, 1'b0);
    push_req(MODE_LOAD, 4'h3, 1'b0, 1'b0);
    push_req(MODE_BUILD, 4'hF, 1'b1, 1'b0);
    push_req(MODE_QUERY, 4'hE, 1'b0, 1'b0);
    push_req(MODE_QUERY, 4'h3, 1'b1, 1'b0);
    push_req(MODE_QUERY, 4'h5, 1'b0, 1'b0);
    push_req(MODE_QUERY, 4'h1, 1'b0, 1'b0);
    push_req(MODE_QUERY, 4'h0, 1'b1, 1'b0);
    push_req(MODE_QUERY, 4'hB, 1'b1, 1'b0);
    push_req(MODE_QUERY, 4'h0, 1'b0, 1'b0);
    push_req(MODE_BUILD, 4'h0, 1'b0, 1'b1);
    push_req(MODE_QUERY, 4'h4, 1'b1, 1'b0);
    push_req(MODE_CLEAR, 4'h0, 1'b0, 1'b0);
    push_req(MODE_QUERY, 4'h0, 1'b1, 1'b0);
  endtask

  // Sender and receiver, both updated on the falling edge.
  int         gap_left   = 0;
  int         burst_left = 0;
  logic [15:0] rx_pat    = '1;
  int         rx_left    = 0;

  always @(negedge clk_i) begin
    trie_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      // The receiver runs a stall pattern taken from rx_pat, picked anew each time it runs out.
      if (rx_left == 0) begin
        case ($urandom_range(0, 3))
          0: rx_pat = '1;
          1: rx_pat = 16'($urandom);
          2: rx_pat = 16'($urandom) | 16'($urandom);
          default: rx_pat = 16'($urandom) & 16'($urandom);
        endcase
        rx_left = 16;
      end
      m_axis_tready <= rx_pat[0];
      rx_pat = {rx_pat[0], rx_pat[15:1]};
      rx_left--;

      // A request on the bus stays put until it has been taken.
      if (!s_axis_tvalid || req_fire) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].drain && answers_due.size() != 0)) begin
          nxt = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, nxt.code};
          s_axis_tuser  <= nxt.mode;
          s_axis_tlast  <= nxt.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check answers first, then predict the request taken at this edge.
  always @(posedge clk_i) begin
    trie_req_t r;
    trie_ans_t want;
    trie_ans_t got;
    if (!rst_ni) begin
      req_fire   = 1'b0;
      win_len    = 0;
      store_full = 1'b0;
      trie_bare();
      walk_home();
    end else begin
      req_fire = s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.found  = m_axis_tdata[0];
        got.status = m_axis_tdata[2:1];
        got.done   = m_axis_tlast;
        if (answers_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("%0t: answer with nothing pending: found %0d done %0d status %0d",
                     $time, got.found, got.done, got.status);
        end else begin
          want = answers_due.pop_front();
          if (got.found !== want.found) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("%0t: found mismatch, expected %0d, actual %0d",
                       $time, want.found, got.found);
          end
          if (got.done !== want.done) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("%0t: query_done mismatch, expected %0d, actual %0d",
                       $time, want.done, got.done);
          end
          if (got.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("%0t: status mismatch, expected %0d, actual %0d",
                       $time, want.status, got.status);
          end
        end
      end
      if (req_fire) begin
        r.mode  = mode_e'(s_axis_tuser);
        r.code  = s_axis_tdata[3:0];
        r.last  = s_axis_tlast;
        r.drain = 1'b0;
        if (r.mode == MODE_BUILD) begin
          n_builds++;
          if (win_len > widest_build) widest_build = win_len;
        end
        trie_model_step(r, want);
        if (want.done) n_queries++;
        if (want.found) n_found++;
        if (want.status == STATUS_WFULL) n_refused++;
        answers_due.push_back(want);
        accepted_reqs++;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    load_directed();
    // The first random pass overfills the window so that loads get refused.
    add_scenario(WINDOW_MAX + $urandom_range(1, 6), 1'b1);
    while (req_backlog.size() < RANDOM_REQS + 22) begin
      if ($urandom_range(0, 24) == 0)
        add_scenario(WINDOW_MAX + $urandom_range(0, 6), $urandom_range(0, 3) == 0);
      else if ($urandom_range(0, 5) == 0)
        add_scenario($urandom_range(13, 24), $urandom_range(0, 3) == 0);
      else
        add_scenario($urandom_range(1, 12), $urandom_range(0, 3) == 0);
    end
    total_reqs = req_backlog.size();

    repeat (4) @(posedge clk_i);
    #5 rst_ni = 1'b1;

    wait (accepted_reqs == total_reqs && answers_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt > REPORT_LIMIT)
      $display("%0d further mismatches were not printed", err_cnt - REPORT_LIMIT);
    $display("Sent %0d requests: %0d builds (widest window %0d bases), %0d loads refused.",
             accepted_reqs, n_builds, widest_build, n_refused);
    $display("Finished %0d pattern queries, %0d of them found.", n_queries, n_found);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the longest run this stimulus can take.
  initial begin
    #(64'd120_000_000);
    $display("timeout with %0d answers still pending", answers_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
